FILE: src/longest_prefix_route_lookup_defines.svh
// Assertion macros shared by the route lookup RTL.
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_DEFINES_SVH

`ifndef SYNTHESIS
`define LPRL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LPRL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPRL_ASSERT(lbl, prop, msg)
`define LPRL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: src/lprl_pkg.sv
// Types and constants shared by the route lookup modules.
package lprl_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = 4;
    localparam int ADDR_W        = 32;
    localparam int PORT_W        = 2;
    localparam int IN_TDATA_W    = 136;
    localparam int OUT_TDATA_W   = 40;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
        logic              valid;
    } wr_t;

    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] addr;
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
    } cand_t;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
    } res_t;

endpackage

FILE: src/lprl_cell.sv
// One table slot of the lookup chain: holds an entry and refines the passing candidate.
module lprl_cell
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [lprl_pkg::IDX_W-1:0]     cell_idx,
    input  lprl_pkg::wr_t                  wr,
    input  lprl_pkg::cand_t                cand_in,
    output lprl_pkg::cand_t                cand_out
);

    logic                          valid_reg;
    logic [lprl_pkg::ADDR_W-1:0]   dest_reg;
    logic [lprl_pkg::ADDR_W-1:0]   mask_reg;
    logic [lprl_pkg::ADDR_W-1:0]   gateway_reg;
    logic [lprl_pkg::PORT_W-1:0]   port_reg;
    lprl_pkg::cand_t               cand_reg;
    lprl_pkg::cand_t               cand_next;
    logic                          wr_sel;
    logic                          match;
    logic                          take;

    assign wr_sel = wr.en && (wr.idx == cell_idx);
    assign match  = valid_reg && (((dest_reg ^ cand_in.addr) & mask_reg) == '0);
    assign take   = match && (!cand_in.found || (mask_reg > cand_in.mask));

    always_comb
    begin
        cand_next = cand_in;
        if (take)
        begin
            cand_next.found   = 1'b1;
            cand_next.idx     = cell_idx;
            cand_next.mask    = mask_reg;
            cand_next.gateway = gateway_reg;
            cand_next.port    = port_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cand_reg  <= '0;
        end
        else
        begin
            if (wr_sel)
            begin
                valid_reg <= wr.valid;
            end
            cand_reg <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_sel)
        begin
            dest_reg    <= wr.dest;
            mask_reg    <= wr.mask;
            gateway_reg <= wr.gateway;
            port_reg    <= wr.port;
        end
    end

    assign cand_out = cand_reg;

endmodule

FILE: src/longest_prefix_route_lookup.sv
// Top level of the longest-prefix route lookup: stream ports, control and the chain of slots.
// A write beat updates its slot at once and registers its all-zero result, so writes can
// follow each other every cycle while the output is not stalled. A lookup beat walks the
// chain of TABLE_ENTRIES slot cells, one cell per cycle, and its result is registered from
// the last cell into the output register; the next beat is taken once the result has left the
// chain. A finished result waits in the output register while the next beat is accepted;
// a second pending result stalls the input, as does a lookup in the chain.
`include "longest_prefix_route_lookup_defines.svh"

module longest_prefix_route_lookup
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // entry_index, entry_dest, entry_mask, entry_gateway, entry_port, entry_valid,
    // lookup_addr, zero pad
    input  logic [lprl_pkg::IN_TDATA_W-1:0]      s_tdata,
    // kind
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // match_index, match_gateway, match_port, zero pad
    output logic [lprl_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // hit
    output logic                                 m_tuser
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_HOLD} state_t;

    state_t                state_reg, state_next;
    logic                  m_vld_reg, m_vld_next;
    lprl_pkg::res_t        out_reg, out_next;
    lprl_pkg::res_t        pend_reg, pend_next;
    lprl_pkg::wr_t         wr;
    lprl_pkg::cand_t       chain [lprl_pkg::TABLE_ENTRIES+1];
    logic [lprl_pkg::TABLE_ENTRIES:1] chain_vld;
    lprl_pkg::res_t        tail_res;
    lprl_pkg::res_t        zero_res;
    logic                  s_acc;
    logic                  out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_vld_reg || m_tready;

    assign wr.en      = s_acc && (s_tuser == lprl_pkg::KIND_WRITE);
    assign wr.idx     = s_tdata[3:0];
    assign wr.dest    = s_tdata[35:4];
    assign wr.mask    = s_tdata[67:36];
    assign wr.gateway = s_tdata[99:68];
    assign wr.port    = s_tdata[101:100];
    assign wr.valid   = s_tdata[102];

    assign chain[0].vld     = s_acc && (s_tuser == lprl_pkg::KIND_LOOKUP);
    assign chain[0].addr    = s_tdata[134:103];
    assign chain[0].found   = 1'b0;
    assign chain[0].idx     = '0;
    assign chain[0].mask    = '0;
    assign chain[0].gateway = '0;
    assign chain[0].port    = '0;

    genvar gi;
    generate
        for (gi = 0; gi < lprl_pkg::TABLE_ENTRIES; gi++)
        begin : g_cell
            lprl_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (lprl_pkg::IDX_W'(gi)),
                .wr       (wr),
                .cand_in  (chain[gi]),
                .cand_out (chain[gi+1])
            );
            assign chain_vld[gi+1] = chain[gi+1].vld;
        end
    endgenerate

    assign zero_res         = '0;
    assign tail_res.hit     = chain[lprl_pkg::TABLE_ENTRIES].found;
    assign tail_res.idx     = chain[lprl_pkg::TABLE_ENTRIES].idx;
    assign tail_res.gateway = chain[lprl_pkg::TABLE_ENTRIES].gateway;
    assign tail_res.port    = chain[lprl_pkg::TABLE_ENTRIES].port;

    always_comb
    begin
        state_next = state_reg;
        m_vld_next = m_vld_reg && !m_tready;
        out_next   = out_reg;
        pend_next  = pend_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    if (s_tuser == lprl_pkg::KIND_LOOKUP)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (out_free)
                    begin
                        m_vld_next = 1'b1;
                        out_next   = zero_res;
                    end
                    else
                    begin
                        pend_next  = zero_res;
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_SCAN:
            begin
                if (chain[lprl_pkg::TABLE_ENTRIES].vld)
                begin
                    if (out_free)
                    begin
                        m_vld_next = 1'b1;
                        out_next   = tail_res;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pend_next  = tail_res;
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    m_vld_next = 1'b1;
                    out_next   = pend_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            m_vld_reg <= 1'b0;
            out_reg   <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            m_vld_reg <= m_vld_next;
            out_reg   <= out_next;
            pend_reg  <= pend_next;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tuser  = out_reg.hit;
    assign m_tdata  = {2'b00, out_reg.port, out_reg.gateway, out_reg.idx};

    // At most one lookup is ever travelling along the chain.
    `LPRL_ASSERT(a_one_in_chain, ($countones(chain_vld) <= 1), "more than one lookup in the chain")
    // While scanning, the lookup must be somewhere in the chain.
    `LPRL_ASSERT(a_scan_has_cand, ((state_reg == ST_SCAN) |-> (chain_vld != '0)), "scan lost its lookup")
    // An accepted lookup enters the first cell on the next edge.
    `LPRL_ASSERT(a_enter_chain, (chain[0].vld |=> chain_vld[1]), "lookup did not enter the chain")
    // A miss carries all-zero match fields.
    `LPRL_ASSERT(a_miss_zero, ((m_tvalid && !m_tuser) |-> (m_tdata == '0)), "miss with non-zero fields")
    // No lookup is in the chain while the block is idle.
    `LPRL_ASSERT(a_idle_empty, ((state_reg == ST_IDLE) |-> (chain_vld == '0)), "chain busy while idle")

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the route lookup: directed and random beats against a route table model.
module tb_top;
    import lprl_pkg::*;

    localparam int   RANDOM_BEATS  = 500;
    localparam int   PRESSURE_BEAT = 250;
    localparam int   IDLE_MAX      = 18;
    localparam int   STALL_LIMIT   = 2000;
    localparam int   DRAIN_CYCLES  = 40;
    localparam res_t NO_ROUTE      = '0;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  slot;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
        logic              valid;
        logic [ADDR_W-1:0] addr;
    } route_beat_t;

    typedef struct {
        route_beat_t beat;
        bit          typed;
        res_t        result;
    } route_step_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    logic [ADDR_W-1:0] route_dest    [TABLE_ENTRIES];
    logic [ADDR_W-1:0] route_mask    [TABLE_ENTRIES];
    logic [ADDR_W-1:0] route_gateway [TABLE_ENTRIES];
    logic [PORT_W-1:0] route_port    [TABLE_ENTRIES];
    logic              route_valid   [TABLE_ENTRIES];

    res_t        pending_routes [$];
    route_step_t directed_steps [$];
    int          errors;
    int          writes_sent;
    int          lookups_sent;
    int          hits_seen;
    int          results_seen;
    int          rx_stall;
    int          idle_cycles;

    longest_prefix_route_lookup u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_idle(int n);
        return ((n % 60) < 15) ? 0 : $urandom_range(0, IDLE_MAX);
    endfunction

    // Applies one beat to the route table copy and returns the result it should produce.
    function automatic res_t predict_route(route_beat_t b);
        res_t r;
        r = NO_ROUTE;
        if (b.kind == KIND_WRITE)
        begin
            route_dest[b.slot]    = b.dest;
            route_mask[b.slot]    = b.mask;
            route_gateway[b.slot] = b.gateway;
            route_port[b.slot]    = b.port;
            route_valid[b.slot]   = b.valid;
        end
        else
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (route_valid[i] && ((route_dest[i] & route_mask[i]) == (b.addr & route_mask[i]))
                    && (!r.hit || route_mask[i] > route_mask[r.idx]))
                begin
                    r.hit     = 1'b1;
                    r.idx     = IDX_W'(i);
                    r.gateway = route_gateway[i];
                    r.port    = route_port[i];
                end
            end
        end
        return r;
    endfunction

    function automatic route_beat_t random_route_beat();
        route_beat_t b;
        int          plen;
        int          j;
        b.kind    = ($urandom_range(0, 9) < 3) ? KIND_WRITE : KIND_LOOKUP;
        b.slot    = IDX_W'($urandom_range(0, TABLE_ENTRIES - 1));
        b.dest    = $urandom;
        b.gateway = ($urandom_range(0, 7) == 0) ? '0 : $urandom;
        b.port    = PORT_W'($urandom_range(0, 3));
        b.valid   = ($urandom_range(0, 6) != 0);
        b.addr    = $urandom;
        plen      = $urandom_range(0, ADDR_W);
        if ($urandom_range(0, 9) == 0)
            b.mask = $urandom;
        else if (plen == 0)
            b.mask = '0;
        else
            b.mask = {ADDR_W{1'b1}} << (ADDR_W - plen);
        // Most lookups are aimed inside the network of some slot so that matches are common.
        if (b.kind == KIND_LOOKUP && $urandom_range(0, 3) != 0)
        begin
            j      = $urandom_range(0, TABLE_ENTRIES - 1);
            b.addr = (route_dest[j] & route_mask[j]) | (b.addr & ~route_mask[j]);
        end
        return b;
    endfunction

    task automatic add_step(route_beat_t b, bit typed, res_t r);
        route_step_t st;
        st.beat   = b;
        st.typed  = typed;
        st.result = r;
        directed_steps.push_back(st);
    endtask

    // Entered and left at a falling edge.
    task automatic send_route_beat(route_beat_t b, int gap, bit typed, res_t typed_result);
        res_t predicted;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.kind;
        s_tdata  <= {1'b0, b.addr, b.valid, b.port, b.gateway, b.mask, b.dest, b.slot};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_route(b);
        pending_routes.push_back(typed ? typed_result : predicted);
        if (b.kind == KIND_WRITE)
            writes_sent++;
        else
            lookups_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        route_beat_t b;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        errors       = 0;
        writes_sent  = 0;
        lookups_sent = 0;
        hits_seen    = 0;
        results_seen = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            route_dest[i]    = '0;
            route_mask[i]    = '0;
            route_gateway[i] = '0;
            route_port[i]    = '0;
            route_valid[i]   = 1'b0;
        end

        add_step({KIND_LOOKUP, 4'd0, 32'h0, 32'h0, 32'h0, 2'd0, 1'b0, 32'h0}, 1'b1, NO_ROUTE);
        add_step({KIND_LOOKUP, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 1'b1,
                  32'hFFFF_FFFF}, 1'b1, NO_ROUTE);
        add_step({KIND_WRITE, 4'd0, 32'h0, 32'h0, 32'h0A00_0001, 2'd3, 1'b1, 32'hFFFF_FFFF},
                 1'b1, NO_ROUTE);
        add_step({KIND_LOOKUP, 4'd0, 32'h0, 32'h0, 32'h0, 2'd0, 1'b0, 32'hDEAD_BEEF},
                 1'b1, {1'b1, 4'd0, 32'h0A00_0001, 2'd3});
        add_step({KIND_WRITE, 4'd15, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0, 2'd1, 1'b1, 32'h0},
                 1'b1, NO_ROUTE);
        add_step({KIND_LOOKUP, 4'd0, 32'h0, 32'h0, 32'h0, 2'd0, 1'b0, 32'hC0A8_01FF},
                 1'b0, NO_ROUTE);
        add_step({KIND_WRITE, 4'd5, 32'hC0A8_0000, 32'hFFFF_0000, 32'hC0A8_0001, 2'd2, 1'b1,
                  32'h0}, 1'b1, NO_ROUTE);
        add_step({KIND_LOOKUP, 4'd0, 32'h0, 32'h0, 32'h0, 2'd0, 1'b0, 32'hC0A8_0105},
                 1'b0, NO_ROUTE);
        add_step({KIND_LOOKUP, 4'd0, 32'h0, 32'h0, 32'h0, 2'd0, 1'b0, 32'hC0A8_0205},
                 1'b0, NO_ROUTE);
        // Same prefix length in a later slot must not displace the earlier one.
        add_step({KIND_WRITE, 4'd7, 32'hC0A8_0000, 32'hFFFF_0000, 32'h1111_1111, 2'd0, 1'b1,
                  32'h0}, 1'b1, NO_ROUTE);
        add_step({KIND_LOOKUP, 4'd0, 32'h0, 32'h0, 32'h0, 2'd0, 1'b0, 32'hC0A8_0909},
                 1'b0, NO_ROUTE);
        add_step({KIND_WRITE, 4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 1'b1,
                  32'h0}, 1'b1, NO_ROUTE);
        add_step({KIND_LOOKUP, 4'd0, 32'h0, 32'h0, 32'h0, 2'd0, 1'b0, 32'hFFFF_FFFF},
                 1'b1, {1'b1, 4'd3, 32'hFFFF_FFFF, 2'd3});
        add_step({KIND_WRITE, 4'd3, 32'h0, 32'h0, 32'h0, 2'd0, 1'b0, 32'h0}, 1'b1, NO_ROUTE);
        add_step({KIND_LOOKUP, 4'd0, 32'h0, 32'h0, 32'h0, 2'd0, 1'b0, 32'hFFFF_FFFF},
                 1'b1, {1'b1, 4'd0, 32'h0A00_0001, 2'd3});
        // A mask with holes in it still ranks by its plain unsigned value.
        add_step({KIND_WRITE, 4'd9, 32'h0102_0304, 32'h0F0F_0F0F, 32'h5555_AAAA, 2'd2, 1'b1,
                  32'h0}, 1'b1, NO_ROUTE);
        add_step({KIND_LOOKUP, 4'd0, 32'h0, 32'h0, 32'h0, 2'd0, 1'b0, 32'h7172_7374},
                 1'b0, NO_ROUTE);
        add_step({KIND_WRITE, 4'd12, 32'hA5A5_5A5A, 32'hFFFF_FFF0, 32'h1234_5678, 2'd1, 1'b0,
                  32'h8765_4321}, 1'b1, NO_ROUTE);
        add_step({KIND_WRITE, 4'd0, 32'h0, 32'h0, 32'h0, 2'd0, 1'b0, 32'h0}, 1'b1, NO_ROUTE);
        add_step({KIND_LOOKUP, 4'd0, 32'h0, 32'h0, 32'h0, 2'd0, 1'b0, 32'h0101_0101},
                 1'b0, NO_ROUTE);
        add_step({KIND_LOOKUP, 4'd0, 32'h0, 32'h0, 32'h0, 2'd0, 1'b0, 32'h0},
                 1'b0, NO_ROUTE);
        add_step({KIND_LOOKUP, 4'd0, 32'h0, 32'h0, 32'h0, 2'd0, 1'b0, 32'hC0A8_0105},
                 1'b0, NO_ROUTE);

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        for (int n = 0; n < directed_steps.size(); n++)
            send_route_beat(directed_steps[n].beat, draw_idle(n), directed_steps[n].typed,
                            directed_steps[n].result);

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == PRESSURE_BEAT && pending_routes.size() != 0)
            begin
                s_tvalid <= 1'b0;
                while (pending_routes.size() != 0)
                    @(negedge clk);
            end
            b = random_route_beat();
            send_route_beat(b, draw_idle(n), 1'b0, NO_ROUTE);
        end

        s_tvalid <= 1'b0;
        while (pending_routes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("tb: %0d table writes and %0d lookups sent, %0d lookups found a route",
                 writes_sent, lookups_sent, hits_seen);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        m_tready = 1'b0;
        rx_stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_stall > 0)
            begin
                m_tready <= 1'b0;
                rx_stall--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : route_check
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_routes.size() == 0)
            begin
                $error("result beat arrived with no lookup or write outstanding");
                errors++;
            end
            else
            begin
                want = pending_routes.pop_front();
                if (m_tuser !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, m_tuser);
                    errors++;
                end
                if (m_tdata[3:0] !== want.idx)
                begin
                    $error("match_index: expected %0d, got %0d", want.idx, m_tdata[3:0]);
                    errors++;
                end
                if (m_tdata[35:4] !== want.gateway)
                begin
                    $error("match_gateway: expected %h, got %h", want.gateway, m_tdata[35:4]);
                    errors++;
                end
                if (m_tdata[37:36] !== want.port)
                begin
                    $error("match_port: expected %0d, got %0d", want.port, m_tdata[37:36]);
                    errors++;
                end
            end
            if (m_tuser === 1'b1)
                hits_seen++;
            results_seen++;
            rx_stall = draw_idle(results_seen);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule

FILE: longest_prefix_route_lookup.f
+incdir+src
src/lprl_pkg.sv
src/lprl_cell.sv
src/longest_prefix_route_lookup.sv
tb/sv/tb_top.sv
